@@ design/fap_pkg.sv @@
// ----------------------------------------------------------------------------
// fap_pkg: shared types and constants
// Command codes and status flags between the controller and the datapath,
// register indexes and fixed field widths of the paced receive FIFO.
// ----------------------------------------------------------------------------
package fap_pkg;

  localparam int DATA_W     = 8;
  localparam int LEN_W      = 11;
  localparam int CNT_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int CAP_W      = 4;
  localparam int GAP_W      = 16;

  localparam logic [CFG_IDX_W-1:0] REG_FRAMED_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_CAP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_TICKS   = 2'd2;

  localparam logic [CAP_W-1:0] FRAME_CAP_RST = 4'd4;
  localparam logic [GAP_W-1:0] GAP_TICKS_RST = 16'd520;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_BYTE_PUSH,
    CMD_FIRST,
    CMD_EV_RD,
    CMD_EV_DO,
    CMD_OPEN,
    CMD_DISC_STEP,
    CMD_PUT,
    CMD_TICK,
    CMD_LD_RD,
    CMD_LD,
    CMD_C_RD,
    CMD_C_WR,
    CMD_S_RD,
    CMD_S_DATA,
    CMD_FINISH
  } fap_cmd_t;

  typedef struct packed {
    logic framed;
    logic is_tick;
    logic first;
    logic len_zero;
    logic len_big;
    logic rem_zero;
    logic discarding;
    logic ev_needed;
    logic frame_empty;
    logic inflight_done;
    logic ring_empty;
    logic gap_ok;
    logic sent_full;
    logic copy_done;
    logic out_free;
    logic hold;
  } fap_stat_t;

endpackage

@@ design/fap_ifs.sv @@
// ----------------------------------------------------------------------------
// fap_ifs: channel interfaces
// Input item, result item and configuration write channels, valid/ready.
// ----------------------------------------------------------------------------
interface fap_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [7:0]  data_byte;
  logic        first_of_frame;
  logic [10:0] frame_length;
  modport source (output valid, op, data_byte, first_of_frame, frame_length,
                  input ready);
  modport sink (input valid, op, data_byte, first_of_frame, frame_length,
                output ready);
endinterface

interface fap_out_if #(
  parameter int FILL_W   = 11,
  parameter int FRAMES_W = 5
);
  logic                valid;
  logic                ready;
  logic                byte_valid;
  logic [7:0]          out_byte;
  logic                last_of_run;
  logic [31:0]         drop_total;
  logic [FILL_W-1:0]   peak_level;
  logic [FILL_W-1:0]   fill_level;
  logic [FRAMES_W-1:0] frames_held;
  modport source (output valid, byte_valid, out_byte, last_of_run, drop_total,
                  peak_level, fill_level, frames_held, input ready);
  modport sink (input valid, byte_valid, out_byte, last_of_run, drop_total,
                peak_level, fill_level, frames_held, output ready);
endinterface

interface fap_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ design/fap_ram.sv @@
// ----------------------------------------------------------------------------
// fap_ram: generic simple dual-port RAM
// One write port, one read port with registered read data held between reads.
// ----------------------------------------------------------------------------
module fap_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/fap_ctrl.sv @@
// ----------------------------------------------------------------------------
// fap_ctrl: sequencing controller
// Steps one input item through push, eviction, frame load and pacing.
// ----------------------------------------------------------------------------
module fap_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  fap_pkg::fap_stat_t stat,
  output fap_pkg::fap_cmd_t  cmd
);
  import fap_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_FCHK, S_EVCHK, S_EVDO, S_PUT, S_PACE,
    S_LD, S_COPY, S_CWR, S_DATA, S_FIN
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = CMD_NONE;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd        = CMD_LOAD;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        if (stat.is_tick) begin
          cmd        = CMD_TICK;
          state_next = S_PACE;
        end else if (!stat.framed) begin
          cmd        = CMD_BYTE_PUSH;
          state_next = S_FIN;
        end else if (stat.first) begin
          cmd        = CMD_FIRST;
          state_next = S_FCHK;
        end else if (stat.rem_zero) begin
          state_next = S_FIN;
        end else if (stat.discarding) begin
          cmd        = CMD_DISC_STEP;
          state_next = S_FIN;
        end else begin
          cmd        = CMD_PUT;
          state_next = S_FIN;
        end
      end
      S_FCHK: begin
        if (stat.len_zero || stat.len_big) begin
          state_next = S_FIN;
        end else begin
          state_next = S_EVCHK;
        end
      end
      S_EVCHK: begin
        if (stat.ev_needed) begin
          cmd        = CMD_EV_RD;
          state_next = S_EVDO;
        end else begin
          cmd        = CMD_OPEN;
          state_next = S_PUT;
        end
      end
      S_EVDO: begin
        cmd        = CMD_EV_DO;
        state_next = S_EVCHK;
      end
      S_PUT: begin
        cmd        = CMD_PUT;
        state_next = S_FIN;
      end
      S_PACE: begin
        if (stat.sent_full) begin
          state_next = S_FIN;
        end else if (stat.framed) begin
          if (stat.inflight_done) begin
            if (stat.frame_empty) begin
              state_next = S_FIN;
            end else begin
              cmd        = CMD_LD_RD;
              state_next = S_LD;
            end
          end else if (!stat.gap_ok) begin
            state_next = S_FIN;
          end else begin
            cmd        = CMD_S_RD;
            state_next = S_DATA;
          end
        end else if (stat.ring_empty || !stat.gap_ok) begin
          state_next = S_FIN;
        end else begin
          cmd        = CMD_S_RD;
          state_next = S_DATA;
        end
      end
      S_LD: begin
        cmd        = CMD_LD;
        state_next = S_COPY;
      end
      S_COPY: begin
        if (stat.copy_done) begin
          state_next = S_PACE;
        end else begin
          cmd        = CMD_C_RD;
          state_next = S_CWR;
        end
      end
      S_CWR: begin
        cmd        = CMD_C_WR;
        state_next = S_COPY;
      end
      S_DATA: begin
        // previous byte must leave the hold stage first
        if (!stat.hold || stat.out_free) begin
          cmd        = CMD_S_DATA;
          state_next = S_PACE;
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd        = CMD_FINISH;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ design/fap_dpath.sv @@
// ----------------------------------------------------------------------------
// fap_dpath: FIFO datapath
// Ring, frame queue and in-flight buffers, pointers, counters, pacer time
// and the hold and output result registers.
// ----------------------------------------------------------------------------
module fap_dpath #(
  parameter int RING_BYTES      = 1024,
  parameter int FRAME_SLOTS     = 16,
  parameter int MAX_FRAME_BYTES = 512,
  parameter int SENDS_PER_TICK  = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  fap_pkg::fap_cmd_t                      cmd,
  output fap_pkg::fap_stat_t                     stat,
  input  logic                                   in_op,
  input  logic [fap_pkg::DATA_W-1:0]             in_byte,
  input  logic                                   in_first,
  input  logic [fap_pkg::LEN_W-1:0]              in_len,
  input  logic                                   cfg_valid,
  input  logic [fap_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [fap_pkg::CFG_DATA_W-1:0]         cfg_data,
  input  logic                                   out_ready,
  output logic                                   out_valid,
  output logic                                   out_byte_valid,
  output logic [fap_pkg::DATA_W-1:0]             out_byte,
  output logic                                   out_last,
  output logic [fap_pkg::CNT_W-1:0]              out_drop,
  output logic [$clog2(RING_BYTES+1)-1:0]        out_peak,
  output logic [$clog2(RING_BYTES+1)-1:0]        out_fill,
  output logic [$clog2(FRAME_SLOTS+1)-1:0]       out_frames
);
  import fap_pkg::*;

  localparam int PW  = $clog2(RING_BYTES);
  localparam int CW  = $clog2(RING_BYTES + 1);
  localparam int FW  = $clog2(FRAME_SLOTS);
  localparam int FCW = $clog2(FRAME_SLOTS + 1);
  localparam int LW  = $clog2(MAX_FRAME_BYTES + 1);
  localparam int IW  = $clog2(MAX_FRAME_BYTES);
  localparam int SW  = $clog2(SENDS_PER_TICK + 1);
  localparam int XW  = ((CW > LEN_W) ? CW : LEN_W) + 1;

  // configuration
  logic              framed_mode;
  logic [CAP_W-1:0]  frame_cap;
  logic [GAP_W-1:0]  gap_ticks;
  // latched item
  logic              op_q;
  logic [DATA_W-1:0] byte_q;
  logic              first_q;
  logic [LEN_W-1:0]  len_q;
  // buffers
  logic [PW-1:0]     ring_head, ring_tail;
  logic [CW-1:0]     ring_fill, fill_peak;
  logic [FW-1:0]     slot_wr, slot_rd;
  logic [FCW-1:0]    frame_fill;
  logic [LW-1:0]     inf_len, inf_pos, copy_cnt;
  logic [CNT_W-1:0]  now_ticks, last_send, drop_cnt;
  logic [LEN_W-1:0]  bytes_rem;
  logic [LW-1:0]     pend_len;
  logic              discarding;
  logic [SW-1:0]     sent_cnt;
  // hold stage for the newest sent byte
  logic              hold;
  logic [DATA_W-1:0] hold_byte;
  logic [CNT_W-1:0]  hold_drop;
  logic [CW-1:0]     hold_peak, hold_fill;
  logic [FCW-1:0]    hold_frames;

  logic [DATA_W-1:0] ring_rdata, inf_rdata, send_byte;
  logic [LW-1:0]     fl_rdata;
  logic              ring_we, ring_re, fl_we, fl_re, inf_we, inf_re;

  logic [XW-1:0]     part_w, part_wc;
  logic              part_open;
  logic [1:0]        first_drops;
  logic [CW-1:0]     ev_amt, fill_inc;
  logic [LW-1:0]     ld_len;
  logic              out_free, len_big, space_short;

  function automatic logic [PW-1:0] ring_add(input logic [PW-1:0] p, input logic [CW-1:0] n);
    logic [CW:0] s;
    s = (CW+1)'(p) + (CW+1)'(n);
    if (s >= (CW+1)'(RING_BYTES)) begin
      s = s - (CW+1)'(RING_BYTES);
    end
    return s[PW-1:0];
  endfunction

  function automatic logic [PW-1:0] ring_sub(input logic [PW-1:0] p, input logic [CW-1:0] n);
    logic [CW:0] s;
    s = (CW+1)'(p) + (CW+1)'(RING_BYTES) - (CW+1)'(n);
    if (s >= (CW+1)'(RING_BYTES)) begin
      s = s - (CW+1)'(RING_BYTES);
    end
    return s[PW-1:0];
  endfunction

  function automatic logic [PW-1:0] ring_inc(input logic [PW-1:0] p);
    return (p == PW'(RING_BYTES - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [FW-1:0] slot_inc(input logic [FW-1:0] p);
    return (p == FW'(FRAME_SLOTS - 1)) ? '0 : p + 1'b1;
  endfunction

  // partial datagram to back out when a new first byte arrives mid-frame
  always_comb begin
    part_open = !discarding && (bytes_rem != '0);
    if (XW'(pend_len) >= XW'(bytes_rem)) begin
      part_w = XW'(pend_len) - XW'(bytes_rem);
    end else begin
      part_w = '0;
    end
    part_wc = (part_w > XW'(ring_fill)) ? XW'(ring_fill) : part_w;
  end

  assign len_big     = (XW'(len_q) > XW'(MAX_FRAME_BYTES)) || (XW'(len_q) > XW'(RING_BYTES));
  assign space_short = (XW'(ring_fill) + XW'(len_q)) > XW'(RING_BYTES);
  assign first_drops = {1'b0, part_open} + {1'b0, (len_q != '0) && len_big};
  assign ev_amt      = (CW'(fl_rdata) > ring_fill) ? ring_fill : CW'(fl_rdata);
  assign ld_len      = (fl_rdata > LW'(MAX_FRAME_BYTES)) ? LW'(MAX_FRAME_BYTES) : fl_rdata;
  assign fill_inc    = ring_fill + 1'b1;
  assign out_free    = !out_valid || out_ready;
  assign send_byte   = framed_mode ? inf_rdata : ring_rdata;

  always_comb begin
    stat.framed        = framed_mode;
    stat.is_tick       = (op_q == OP_TICK);
    stat.first         = first_q;
    stat.len_zero      = (len_q == '0);
    stat.len_big       = len_big;
    stat.rem_zero      = (bytes_rem == '0);
    stat.discarding    = discarding;
    stat.ev_needed     = (frame_fill != '0) &&
                         ((XW'(frame_fill) >= XW'(frame_cap)) ||
                          (XW'(frame_fill) >= XW'(FRAME_SLOTS)) || space_short);
    stat.frame_empty   = (frame_fill == '0);
    stat.inflight_done = (inf_pos >= inf_len);
    stat.ring_empty    = (ring_fill == '0);
    stat.gap_ok        = ((now_ticks - last_send) >= CNT_W'(gap_ticks));
    stat.sent_full     = (sent_cnt == SW'(SENDS_PER_TICK));
    stat.copy_done     = (copy_cnt == inf_len);
    stat.out_free      = out_free;
    stat.hold          = hold;
  end

  assign ring_we = (cmd == CMD_BYTE_PUSH) || (cmd == CMD_PUT);
  assign ring_re = (cmd == CMD_C_RD) || ((cmd == CMD_S_RD) && !framed_mode);
  assign fl_we   = (cmd == CMD_PUT) && (bytes_rem == LEN_W'(1)) &&
                   (XW'(frame_fill) < XW'(FRAME_SLOTS));
  assign fl_re   = (cmd == CMD_EV_RD) || (cmd == CMD_LD_RD);
  assign inf_we  = (cmd == CMD_C_WR);
  assign inf_re  = (cmd == CMD_S_RD) && framed_mode;

  fap_ram #(.WIDTH(DATA_W), .DEPTH(RING_BYTES)) u_ring (
    .clk(clk), .we(ring_we), .waddr(ring_head), .wdata(byte_q),
    .re(ring_re), .raddr(ring_tail), .rdata(ring_rdata)
  );

  fap_ram #(.WIDTH(LW), .DEPTH(FRAME_SLOTS)) u_flen (
    .clk(clk), .we(fl_we), .waddr(slot_wr), .wdata(pend_len),
    .re(fl_re), .raddr(slot_rd), .rdata(fl_rdata)
  );

  fap_ram #(.WIDTH(DATA_W), .DEPTH(MAX_FRAME_BYTES)) u_inflight (
    .clk(clk), .we(inf_we), .waddr(copy_cnt[IW-1:0]), .wdata(ring_rdata),
    .re(inf_re), .raddr(inf_pos[IW-1:0]), .rdata(inf_rdata)
  );

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (cmd == CMD_LOAD) begin
      byte_q  <= in_byte;
      first_q <= in_first;
      len_q   <= in_len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      framed_mode <= 1'b0;
      frame_cap   <= FRAME_CAP_RST;
      gap_ticks   <= GAP_TICKS_RST;
      op_q        <= OP_PUSH;
      ring_head   <= '0;
      ring_tail   <= '0;
      ring_fill   <= '0;
      fill_peak   <= '0;
      slot_wr     <= '0;
      slot_rd     <= '0;
      frame_fill  <= '0;
      inf_len     <= '0;
      inf_pos     <= '0;
      copy_cnt    <= '0;
      now_ticks   <= '0;
      last_send   <= '0;
      drop_cnt    <= '0;
      bytes_rem   <= '0;
      pend_len    <= '0;
      discarding  <= 1'b0;
      sent_cnt    <= '0;
      hold        <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && out_ready && (cmd != CMD_FINISH) &&
          !((cmd == CMD_S_DATA) && hold)) begin
        out_valid <= 1'b0;
      end

      if (cfg_valid) begin
        case (cfg_index)
          REG_FRAMED_MODE: begin
            if (cfg_data[0] != framed_mode) begin
              ring_head  <= '0;
              ring_tail  <= '0;
              ring_fill  <= '0;
              slot_wr    <= '0;
              slot_rd    <= '0;
              frame_fill <= '0;
              inf_len    <= '0;
              inf_pos    <= '0;
              bytes_rem  <= '0;
              pend_len   <= '0;
              discarding <= 1'b0;
            end
            framed_mode <= cfg_data[0];
          end
          REG_FRAME_CAP: frame_cap <= cfg_data[CAP_W-1:0];
          REG_GAP_TICKS: gap_ticks <= cfg_data[GAP_W-1:0];
          default: ;
        endcase
      end

      case (cmd)
        CMD_LOAD: op_q <= in_op;
        CMD_BYTE_PUSH: begin
          ring_head <= ring_inc(ring_head);
          if (XW'(ring_fill) >= XW'(RING_BYTES)) begin
            ring_tail <= ring_inc(ring_tail);
            drop_cnt  <= drop_cnt + 1'b1;
          end else begin
            ring_fill <= fill_inc;
            if (fill_inc > fill_peak) begin
              fill_peak <= fill_inc;
            end
          end
        end
        CMD_FIRST: begin
          if (part_open) begin
            ring_head <= ring_sub(ring_head, part_wc[CW-1:0]);
            ring_fill <= ring_fill - part_wc[CW-1:0];
          end
          drop_cnt <= drop_cnt + CNT_W'(first_drops);
          if ((len_q != '0) && len_big && (len_q > LEN_W'(1))) begin
            discarding <= 1'b1;
            bytes_rem  <= len_q - 1'b1;
          end else begin
            discarding <= 1'b0;
            bytes_rem  <= '0;
          end
        end
        CMD_EV_DO: begin
          slot_rd    <= slot_inc(slot_rd);
          frame_fill <= frame_fill - 1'b1;
          ring_tail  <= ring_add(ring_tail, ev_amt);
          ring_fill  <= ring_fill - ev_amt;
          drop_cnt   <= drop_cnt + 1'b1;
        end
        CMD_OPEN: begin
          pend_len  <= len_q[LW-1:0];
          bytes_rem <= len_q;
        end
        CMD_DISC_STEP: begin
          bytes_rem <= bytes_rem - 1'b1;
          if (bytes_rem == LEN_W'(1)) begin
            discarding <= 1'b0;
          end
        end
        CMD_PUT: begin
          ring_head <= ring_inc(ring_head);
          ring_fill <= fill_inc;
          if (fill_inc > fill_peak) begin
            fill_peak <= fill_inc;
          end
          bytes_rem <= bytes_rem - 1'b1;
          if (fl_we) begin
            slot_wr    <= slot_inc(slot_wr);
            frame_fill <= frame_fill + 1'b1;
          end
        end
        CMD_TICK: begin
          now_ticks <= now_ticks + 1'b1;
          sent_cnt  <= '0;
        end
        CMD_LD: begin
          slot_rd    <= slot_inc(slot_rd);
          frame_fill <= frame_fill - 1'b1;
          inf_len    <= ld_len;
          inf_pos    <= '0;
          copy_cnt   <= '0;
        end
        CMD_C_RD: begin
          ring_tail <= ring_inc(ring_tail);
          if (ring_fill != '0) begin
            ring_fill <= ring_fill - 1'b1;
          end
        end
        CMD_C_WR: copy_cnt <= copy_cnt + 1'b1;
        CMD_S_RD: begin
          if (!framed_mode) begin
            ring_tail <= ring_inc(ring_tail);
            if (ring_fill != '0) begin
              ring_fill <= ring_fill - 1'b1;
            end
          end
        end
        CMD_S_DATA: begin
          if (hold) begin
            out_valid      <= 1'b1;
            out_byte_valid <= 1'b1;
            out_byte       <= hold_byte;
            out_last       <= 1'b0;
            out_drop       <= hold_drop;
            out_peak       <= hold_peak;
            out_fill       <= hold_fill;
            out_frames     <= hold_frames;
          end
          hold        <= 1'b1;
          hold_byte   <= send_byte;
          hold_drop   <= drop_cnt;
          hold_peak   <= fill_peak;
          hold_fill   <= ring_fill;
          hold_frames <= frame_fill;
          if (framed_mode) begin
            inf_pos <= inf_pos + 1'b1;
          end
          last_send <= last_send + CNT_W'(gap_ticks);
          sent_cnt  <= sent_cnt + 1'b1;
        end
        CMD_FINISH: begin
          out_valid <= 1'b1;
          out_last  <= 1'b1;
          if (hold) begin
            hold           <= 1'b0;
            out_byte_valid <= 1'b1;
            out_byte       <= hold_byte;
            out_drop       <= hold_drop;
            out_peak       <= hold_peak;
            out_fill       <= hold_fill;
            out_frames     <= hold_frames;
          end else begin
            out_byte_valid <= 1'b0;
            out_byte       <= '0;
            out_drop       <= drop_cnt;
            out_peak       <= fill_peak;
            out_fill       <= ring_fill;
            out_frames     <= frame_fill;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ design/frame_aligned_paced_rx_fifo_core.sv @@
// ----------------------------------------------------------------------------
// frame_aligned_paced_rx_fifo_core: paced receive FIFO, byte or frame mode
// Buffers received bytes in a ring and sends them out at a fixed tick gap.
//
// Channels: rx takes one item per transfer (op 0 push a byte, op 1 a tick);
// tx returns results, one per push and one or more per tick, the final one
// flagged by last_of_run; cfg writes registers 0 framed_mode, 1 frame_cap,
// 2 gap_ticks and is always ready. Write cfg only with the block idle.
// Sequence: a byte push is loaded, written into the ring and answered with
// its status result; a framed first byte is checked, evicts frames one at a
// time (a length read, then the eviction) while the queue or ring is too full,
// then opens its frame and is stored, unless dropped or of zero length. A tick
// stages each byte sent, and a frame is copied into the in-flight buffer
// through the single ring read port, a read then a write per byte. One item
// is worked at a time; rx is ready again as its last result enters the output register.
// Reset clears all pointers, counters and time and restores register defaults;
// buffer memories are not cleared. When tx stalls, the held result and one
// staged byte wait and the sequencer pauses; nothing is lost.
// ----------------------------------------------------------------------------
module frame_aligned_paced_rx_fifo_core #(
  parameter int RING_BYTES      = 1024,
  parameter int FRAME_SLOTS     = 16,
  parameter int MAX_FRAME_BYTES = 512,
  parameter int SENDS_PER_TICK  = 16
) (
  input  logic   clk,
  input  logic   rst,
  fap_in_if.sink   rx,
  fap_out_if.source tx,
  fap_cfg_if.sink  cfg
);
  import fap_pkg::*;

  fap_cmd_t  cmd;
  fap_stat_t stat;

  assign cfg.ready = 1'b1;

  fap_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(rx.valid), .in_ready(rx.ready),
    .stat(stat), .cmd(cmd)
  );

  fap_dpath #(
    .RING_BYTES(RING_BYTES), .FRAME_SLOTS(FRAME_SLOTS),
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES), .SENDS_PER_TICK(SENDS_PER_TICK)
  ) u_dpath (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .in_op(rx.op), .in_byte(rx.data_byte), .in_first(rx.first_of_frame),
    .in_len(rx.frame_length),
    .cfg_valid(cfg.valid), .cfg_index(cfg.index), .cfg_data(cfg.data),
    .out_ready(tx.ready), .out_valid(tx.valid), .out_byte_valid(tx.byte_valid),
    .out_byte(tx.out_byte), .out_last(tx.last_of_run), .out_drop(tx.drop_total),
    .out_peak(tx.peak_level), .out_fill(tx.fill_level), .out_frames(tx.frames_held)
  );

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (rx.valid && rx.ready) |=> !rx.ready)
    else $error("rx ready right after a transfer");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    tx.valid |-> (tx.fill_level <= RING_BYTES))
    else $error("fill level above ring size");

  a_frames_bound: assert property (@(posedge clk) disable iff (rst)
    tx.valid |-> (tx.frames_held <= FRAME_SLOTS))
    else $error("frames held above slot count");

  a_peak: assert property (@(posedge clk) disable iff (rst)
    tx.valid |-> (tx.peak_level >= tx.fill_level))
    else $error("peak level below fill level");

endmodule
